// ===== rtl/tcce_pkg.sv =====
package tcce_pkg;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int COORD_W = 10;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [3:0] FORE_RESET = 4'd7;
  localparam logic [3:0] BACK_RESET = 4'd1;

  localparam logic [7:0] LEVEL_BRIGHT_ON  = 8'd255;
  localparam logic [7:0] LEVEL_BRIGHT_OFF = 8'd82;
  localparam logic [7:0] LEVEL_NORMAL_ON  = 8'd172;
  localparam logic [7:0] LEVEL_NORMAL_OFF = 8'd0;

  typedef enum logic [1:0] {
    CMD_DRAW   = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_SCROLL = 2'd2
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t            cmd;
    logic [7:0]           glyph;
    logic [COORD_W-1:0]   px;
    logic [COORD_W-1:0]   py;
    logic [7:0]           fg_red;
    logic [7:0]           fg_green;
    logic [7:0]           fg_blue;
    logic [7:0]           bg_red;
    logic [7:0]           bg_green;
    logic [7:0]           bg_blue;
    logic                 last;
  } cmd_item_t;

  function automatic logic [7:0] level(logic bright, logic on);
    logic [7:0] v;
    if (bright) begin
      v = on ? LEVEL_BRIGHT_ON : LEVEL_BRIGHT_OFF;
    end else begin
      v = on ? LEVEL_NORMAL_ON : LEVEL_NORMAL_OFF;
    end
    return v;
  endfunction

  function automatic cmd_item_t make_item(cmd_code_t cmd, logic [7:0] glyph,
                                          logic [COORD_W-1:0] px,
                                          logic [COORD_W-1:0] py,
                                          logic [3:0] fore, logic [3:0] back,
                                          logic last);
    cmd_item_t it;
    it.cmd      = cmd;
    it.glyph    = glyph;
    it.px       = px;
    it.py       = py;
    it.fg_red   = level(fore[3], fore[2]);
    it.fg_green = level(fore[3], fore[1]);
    it.fg_blue  = level(fore[3], fore[0]);
    it.bg_red   = level(back[3], back[2]);
    it.bg_green = level(back[3], back[1]);
    it.bg_blue  = level(back[3], back[0]);
    it.last     = last;
    return it;
  endfunction

endpackage

// ===== rtl/tcce_ifs.sv =====
interface tcce_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface tcce_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic [7:0]                   glyph;
  logic [tcce_pkg::COORD_W-1:0] px;
  logic [tcce_pkg::COORD_W-1:0] py;
  logic [7:0]                   fg_red;
  logic [7:0]                   fg_green;
  logic [7:0]                   fg_blue;
  logic [7:0]                   bg_red;
  logic [7:0]                   bg_green;
  logic [7:0]                   bg_blue;
  logic                         last;

  modport source (output valid, output cmd, output glyph, output px, output py,
                  output fg_red, output fg_green, output fg_blue,
                  output bg_red, output bg_green, output bg_blue, output last,
                  input ready);
  modport sink   (input valid, input cmd, input glyph, input px, input py,
                  input fg_red, input fg_green, input fg_blue,
                  input bg_red, input bg_green, input bg_blue, input last,
                  output ready);
endinterface

// ===== rtl/text_console_cursor_engine_unit.sv =====
// A character is captured in the input register, decoded from there once the command
// queue has room for two commands, and its commands are written into the queue for cmds.
// Throughput: one character per cycle while the four-entry queue has room for two commands;
// one command leaves per cycle while cmds.ready is high, so two-command characters set the pace.
// Reset (rst, synchronous): cursor at origin, no escape pending, colors 7 on 1,
// input register and command queue empty.
module text_console_cursor_engine_unit #(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 30,
  parameter int CELL_WIDTH  = 10,
  parameter int CELL_HEIGHT = 20
) (
  input  logic          clk,
  input  logic          rst,
  tcce_char_if.sink     chars,
  tcce_cmd_if.source    cmds
);

  logic [7:0]                          ch_q;
  logic                                ch_valid;
  logic                                fire;
  logic                                valid0;
  logic                                valid1;
  tcce_pkg::cmd_item_t                 item0;
  tcce_pkg::cmd_item_t                 item1;
  tcce_pkg::cmd_item_t                 head;
  logic [tcce_pkg::OUTQ_CNT_W-1:0]     count;
  logic                                rd;

  assign fire        = ch_valid && (count <= tcce_pkg::OUTQ_CNT_W'(tcce_pkg::OUTQ_DEPTH - 2));
  assign chars.ready = !ch_valid || fire;
  assign rd          = cmds.valid && cmds.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid <= 1'b0;
    end else if (chars.ready) begin
      ch_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      ch_q <= chars.ch;
    end
  end

  tcce_step #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .CELL_WIDTH  (CELL_WIDTH),
    .CELL_HEIGHT (CELL_HEIGHT)
  ) u_step (
    .clk    (clk),
    .rst    (rst),
    .ch     (ch_q),
    .fire   (fire),
    .valid0 (valid0),
    .valid1 (valid1),
    .item0  (item0),
    .item1  (item1)
  );

  tcce_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .wr0   (fire && valid0),
    .wr1   (fire && valid1),
    .d0    (item0),
    .d1    (item1),
    .rd    (rd),
    .head  (head),
    .count (count)
  );

  assign cmds.valid    = (count != '0);
  assign cmds.cmd      = head.cmd;
  assign cmds.glyph    = head.glyph;
  assign cmds.px       = head.px;
  assign cmds.py       = head.py;
  assign cmds.fg_red   = head.fg_red;
  assign cmds.fg_green = head.fg_green;
  assign cmds.fg_blue  = head.fg_blue;
  assign cmds.bg_red   = head.bg_red;
  assign cmds.bg_green = head.bg_green;
  assign cmds.bg_blue  = head.bg_blue;
  assign cmds.last     = head.last;

endmodule

// ===== rtl/tcce_step.sv =====
module tcce_step #(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 30,
  parameter int CELL_WIDTH  = 10,
  parameter int CELL_HEIGHT = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          ch,
  input  logic                fire,
  output logic                valid0,
  output logic                valid1,
  output tcce_pkg::cmd_item_t item0,
  output tcce_pkg::cmd_item_t item1
);

  localparam int SCROLL_Y = (ROWS - 1) * CELL_HEIGHT;

  logic [tcce_pkg::ROW_W-1:0] cursor_row;
  logic [tcce_pkg::COL_W-1:0] cursor_col;
  logic                       escape_pending;
  logic [3:0]                 fore_index;
  logic [3:0]                 back_index;

  logic [tcce_pkg::ROW_W:0]   row_next;
  logic [tcce_pkg::COL_W:0]   col_next;
  logic                       escape_pending_next;
  logic [3:0]                 fore_index_next;
  logic [3:0]                 back_index_next;

  logic [tcce_pkg::ROW_W-1:0] pos_row;
  logic [tcce_pkg::COL_W-1:0] pos_col;
  logic [11:0]                px_full;
  logic [11:0]                py_full;
  logic [tcce_pkg::COL_W:0]   tab_col;
  logic                       draw;
  logic                       scroll;
  tcce_pkg::cmd_code_t        draw_cmd;
  logic [7:0]                 draw_glyph;
  tcce_pkg::cmd_item_t        draw_item;
  tcce_pkg::cmd_item_t        scroll_item;

  always_comb begin
    row_next            = {1'b0, cursor_row};
    col_next            = {1'b0, cursor_col};
    escape_pending_next = escape_pending;
    fore_index_next     = fore_index;
    back_index_next     = back_index;
    draw                = 1'b0;
    draw_cmd            = tcce_pkg::CMD_DRAW;
    draw_glyph          = ch;
    pos_row             = cursor_row;
    pos_col             = cursor_col;
    tab_col             = {({1'b0, cursor_col[tcce_pkg::COL_W-1:3]} + 5'd1), 3'b000};
    if (escape_pending) begin
      escape_pending_next = 1'b0;
      back_index_next     = ch[7:4];
      fore_index_next     = ch[3:0];
    end else begin
      unique case (ch)
        tcce_pkg::CH_LF: begin
          row_next = {1'b0, cursor_row} + 6'd1;
          col_next = '0;
        end
        tcce_pkg::CH_CR: begin
          col_next = '0;
        end
        tcce_pkg::CH_TAB: begin
          if (tab_col >= 8'(COLUMNS)) begin
            col_next = '0;
            row_next = {1'b0, cursor_row} + 6'd1;
          end else begin
            col_next = tab_col;
          end
        end
        tcce_pkg::CH_FF: begin
          row_next   = '0;
          col_next   = '0;
          draw       = 1'b1;
          draw_cmd   = tcce_pkg::CMD_CLEAR;
          draw_glyph = tcce_pkg::CH_SPACE;
          pos_row    = '0;
          pos_col    = '0;
        end
        tcce_pkg::CH_DEL: begin
          if (cursor_col != '0) begin
            pos_col = cursor_col - 7'd1;
          end else if (cursor_row != '0) begin
            pos_row = cursor_row - 5'd1;
            pos_col = 7'(COLUMNS - 1);
          end
          row_next   = {1'b0, pos_row};
          col_next   = {1'b0, pos_col};
          draw       = 1'b1;
          draw_glyph = tcce_pkg::CH_SPACE;
        end
        tcce_pkg::CH_ESC: begin
          escape_pending_next = 1'b1;
        end
        default: begin
          draw     = 1'b1;
          col_next = {1'b0, cursor_col} + 8'd1;
          if (col_next >= 8'(COLUMNS)) begin
            col_next = '0;
            row_next = {1'b0, cursor_row} + 6'd1;
          end
        end
      endcase
    end
    scroll = (row_next >= 6'(ROWS));
    if (scroll) begin
      row_next = 6'(ROWS - 1);
      col_next = '0;
    end
  end

  assign px_full = 12'(pos_col) * 12'(CELL_WIDTH);
  assign py_full = 12'(pos_row) * 12'(CELL_HEIGHT);

  assign draw_item = tcce_pkg::make_item(draw_cmd, draw_glyph,
                                         px_full[tcce_pkg::COORD_W-1:0],
                                         py_full[tcce_pkg::COORD_W-1:0],
                                         fore_index, back_index, !scroll);
  assign scroll_item = tcce_pkg::make_item(tcce_pkg::CMD_SCROLL, tcce_pkg::CH_SPACE,
                                           '0, tcce_pkg::COORD_W'(SCROLL_Y),
                                           fore_index, back_index, 1'b1);

  assign valid0 = draw || scroll;
  assign valid1 = draw && scroll;
  assign item0  = draw ? draw_item : scroll_item;
  assign item1  = scroll_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row     <= '0;
      cursor_col     <= '0;
      escape_pending <= 1'b0;
      fore_index     <= tcce_pkg::FORE_RESET;
      back_index     <= tcce_pkg::BACK_RESET;
    end else if (fire) begin
      cursor_row     <= row_next[tcce_pkg::ROW_W-1:0];
      cursor_col     <= col_next[tcce_pkg::COL_W-1:0];
      escape_pending <= escape_pending_next;
      fore_index     <= fore_index_next;
      back_index     <= back_index_next;
    end
  end

endmodule

// ===== rtl/tcce_outq.sv =====
module tcce_outq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr0,
  input  logic                                wr1,
  input  tcce_pkg::cmd_item_t                 d0,
  input  tcce_pkg::cmd_item_t                 d1,
  input  logic                                rd,
  output tcce_pkg::cmd_item_t                 head,
  output logic [tcce_pkg::OUTQ_CNT_W-1:0]     count
);

  tcce_pkg::cmd_item_t                 mem [tcce_pkg::OUTQ_DEPTH];
  logic [tcce_pkg::OUTQ_PTR_W-1:0]     wp;
  logic [tcce_pkg::OUTQ_PTR_W-1:0]     rp;
  logic [tcce_pkg::OUTQ_PTR_W-1:0]     wp1;
  logic [tcce_pkg::OUTQ_CNT_W-1:0]     count_next;

  assign wp1  = wp + 2'd1;
  assign head = mem[rp];

  always_comb begin
    count_next = count + tcce_pkg::OUTQ_CNT_W'(wr0) + tcce_pkg::OUTQ_CNT_W'(wr1)
               - tcce_pkg::OUTQ_CNT_W'(rd);
  end

  always_ff @(posedge clk) begin
    if (wr0) begin
      mem[wp] <= d0;
    end
    if (wr1) begin
      mem[wp1] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + tcce_pkg::OUTQ_PTR_W'(wr0) + tcce_pkg::OUTQ_PTR_W'(wr1);
      rp    <= rp + tcce_pkg::OUTQ_PTR_W'(rd);
      count <= count_next;
    end
  end

endmodule

// ===== tb/text_console_cursor_engine_unit_tb.sv =====
module text_console_cursor_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TERM_COLS   = 80;
  localparam int TERM_ROWS   = 30;
  localparam int GLYPH_W     = 10;
  localparam int GLYPH_H     = 20;
  localparam int ITEM_COUNT  = 850;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  class console_scoreboard;
    int                  row;
    int                  col;
    bit                  esc_armed;
    logic [3:0]          fore;
    logic [3:0]          back;
    tcce_pkg::cmd_item_t pending_cmds[$];
    int                  errors;
    bit                  field_bad;

    function new();
      row       = 0;
      col       = 0;
      esc_armed = 0;
      fore      = tcce_pkg::FORE_RESET;
      back      = tcce_pkg::BACK_RESET;
      errors    = 0;
    endfunction

    function logic [7:0] shade(logic [3:0] idx, logic lit);
      logic [7:0] v;
      if (idx[3]) begin
        v = lit ? 8'd255 : 8'd82;
      end else begin
        v = lit ? 8'd172 : 8'd0;
      end
      return v;
    endfunction

    function void push_cmd(tcce_pkg::cmd_code_t cmd, logic [7:0] glyph, int x, int y);
      tcce_pkg::cmd_item_t it;
      it.cmd      = cmd;
      it.glyph    = glyph;
      it.px       = tcce_pkg::COORD_W'(x);
      it.py       = tcce_pkg::COORD_W'(y);
      it.fg_red   = shade(fore, fore[2]);
      it.fg_green = shade(fore, fore[1]);
      it.fg_blue  = shade(fore, fore[0]);
      it.bg_red   = shade(back, back[2]);
      it.bg_green = shade(back, back[1]);
      it.bg_blue  = shade(back, back[0]);
      it.last     = 1'b0;
      pending_cmds.push_back(it);
    endfunction

    function void note_char(logic [7:0] c);
      int first;
      first = pending_cmds.size();
      if (esc_armed) begin
        esc_armed = 0;
        back      = c[7:4];
        fore      = c[3:0];
        return;
      end
      case (c)
        tcce_pkg::CH_LF: begin
          row++;
          col = 0;
        end
        tcce_pkg::CH_CR: begin
          col = 0;
        end
        tcce_pkg::CH_TAB: begin
          col += 8 - (col % 8);
          if (col >= TERM_COLS) begin
            col = 0;
            row++;
          end
        end
        tcce_pkg::CH_FF: begin
          row = 0;
          col = 0;
          push_cmd(tcce_pkg::CMD_CLEAR, tcce_pkg::CH_SPACE, 0, 0);
        end
        tcce_pkg::CH_DEL: begin
          if (col > 0) begin
            col--;
          end else if (row > 0) begin
            row--;
            col = TERM_COLS - 1;
          end
          push_cmd(tcce_pkg::CMD_DRAW, tcce_pkg::CH_SPACE, col * GLYPH_W, row * GLYPH_H);
        end
        tcce_pkg::CH_ESC: begin
          esc_armed = 1;
        end
        default: begin
          push_cmd(tcce_pkg::CMD_DRAW, c, col * GLYPH_W, row * GLYPH_H);
          col++;
          if (col >= TERM_COLS) begin
            col = 0;
            row++;
          end
        end
      endcase
      if (row >= TERM_ROWS) begin
        row = TERM_ROWS - 1;
        col = 0;
        push_cmd(tcce_pkg::CMD_SCROLL, tcce_pkg::CH_SPACE, 0, (TERM_ROWS - 1) * GLYPH_H);
      end
      if (pending_cmds.size() > first) begin
        pending_cmds[pending_cmds.size() - 1].last = 1'b1;
      end
    endfunction

    function void cmp_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, e, a);
        field_bad = 1;
      end
    endfunction

    function void check_cmd(tcce_pkg::cmd_item_t got);
      tcce_pkg::cmd_item_t want;
      if (pending_cmds.size() == 0) begin
        $display("%0t unexpected command: expected none, actual cmd %0d glyph %0d",
                 $time, got.cmd, got.glyph);
        errors++;
        return;
      end
      want      = pending_cmds.pop_front();
      field_bad = 0;
      cmp_field("cmd", want.cmd, got.cmd);
      cmp_field("glyph", want.glyph, got.glyph);
      cmp_field("px", want.px, got.px);
      cmp_field("py", want.py, got.py);
      cmp_field("fg_red", want.fg_red, got.fg_red);
      cmp_field("fg_green", want.fg_green, got.fg_green);
      cmp_field("fg_blue", want.fg_blue, got.fg_blue);
      cmp_field("bg_red", want.bg_red, got.bg_red);
      cmp_field("bg_green", want.bg_green, got.bg_green);
      cmp_field("bg_blue", want.bg_blue, got.bg_blue);
      cmp_field("last", want.last, got.last);
      if (field_bad) begin
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_cmds.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   sent;
  bit   calm;
  int   idle_cycles;

  console_scoreboard sb;

  tcce_char_if chars_if();
  tcce_cmd_if  cmds_if();

  text_console_cursor_engine_unit DUT (
    .clk  (clk),
    .rst  (rst),
    .chars(chars_if),
    .cmds (cmds_if)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic send_char(logic [7:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.ch    <= c;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain_cmds();
    while (sb.outstanding() > 0) @(posedge clk);
  endtask

  task automatic send_random_burst();
    int r;
    int n;
    logic [7:0] ctl[6];
    ctl = '{tcce_pkg::CH_TAB, tcce_pkg::CH_LF, tcce_pkg::CH_FF, tcce_pkg::CH_CR,
            tcce_pkg::CH_ESC, tcce_pkg::CH_DEL};
    r = $urandom_range(0, 99);
    if (r < 30) begin
      send_char(8'($urandom_range(0, 255)));
    end else if (r < 45) begin
      n = $urandom_range(1, 100);
      repeat (n) send_char(8'($urandom_range(8'h20, 8'h7E)));
    end else if (r < 60) begin
      n = $urandom_range(1, 35);
      repeat (n) send_char(tcce_pkg::CH_LF);
    end else if (r < 68) begin
      n = $urandom_range(1, 90);
      repeat (n) send_char(tcce_pkg::CH_DEL);
    end else if (r < 76) begin
      n = $urandom_range(1, 12);
      repeat (n) send_char(tcce_pkg::CH_TAB);
    end else if (r < 86) begin
      send_char(tcce_pkg::CH_ESC);
      send_char(8'($urandom_range(0, 255)));
    end else if (r < 92) begin
      send_char($urandom_range(0, 1) ? tcce_pkg::CH_CR : tcce_pkg::CH_LF);
    end else if (r < 94) begin
      send_char(tcce_pkg::CH_FF);
    end else begin
      send_char(tcce_pkg::CH_ESC);
      send_char(ctl[$urandom_range(0, 5)]);
    end
  endtask

  initial begin
    cmds_if.ready = 1'b0;
    @(negedge rst);
    forever begin
      cmds_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      if (!calm) begin
        int g;
        g = pick_gap();
        if (g > 0) begin
          cmds_if.ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    tcce_pkg::cmd_item_t got;
    if (!rst) begin
      if (cmds_if.valid && cmds_if.ready) begin
        got.cmd      = tcce_pkg::cmd_code_t'(cmds_if.cmd);
        got.glyph    = cmds_if.glyph;
        got.px       = cmds_if.px;
        got.py       = cmds_if.py;
        got.fg_red   = cmds_if.fg_red;
        got.fg_green = cmds_if.fg_green;
        got.fg_blue  = cmds_if.fg_blue;
        got.bg_red   = cmds_if.bg_red;
        got.bg_green = cmds_if.bg_green;
        got.bg_blue  = cmds_if.bg_blue;
        got.last     = cmds_if.last;
        sb.check_cmd(got);
      end
      if (chars_if.valid && chars_if.ready) begin
        sb.note_char(chars_if.ch);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((chars_if.valid && chars_if.ready) || (cmds_if.valid && cmds_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] opening[$];
    bit paused;
    sb             = new();
    sent           = 0;
    calm           = 0;
    paused         = 0;
    rst            = 1'b1;
    chars_if.valid = 1'b0;
    chars_if.ch    = 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    opening = '{8'h41, 8'h00, 8'hFF, tcce_pkg::CH_TAB, 8'h78, tcce_pkg::CH_TAB,
                tcce_pkg::CH_CR, tcce_pkg::CH_LF, tcce_pkg::CH_LF, tcce_pkg::CH_DEL,
                tcce_pkg::CH_DEL, tcce_pkg::CH_ESC, 8'hF8, 8'h42, tcce_pkg::CH_ESC,
                tcce_pkg::CH_ESC, 8'h43, tcce_pkg::CH_ESC, 8'h00, 8'h44, tcce_pkg::CH_FF,
                tcce_pkg::CH_DEL, tcce_pkg::CH_ESC, 8'h17, 8'h80};
    foreach (opening[i]) begin
      send_char(opening[i]);
    end

    while (sent < ITEM_COUNT) begin
      calm = (sent >= 200 && sent < 300);
      if (!paused && sent >= ITEM_COUNT / 2) begin
        paused = 1;
        chars_if.valid <= 1'b0;
        @(posedge clk);
        drain_cmds();
      end
      send_random_burst();
    end
    calm = 0;
    chars_if.valid <= 1'b0;
    @(posedge clk);

    drain_cmds();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
